### sv/cast_to_scaled_decimal_assert.svh
// Assertion macros for the decimal cast pipeline.
`ifndef CAST_TO_SCALED_DECIMAL_ASSERT_SVH
`define CAST_TO_SCALED_DECIMAL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cstd_pkg.sv
// Types, codes and tables for the decimal cast pipeline.
`timescale 1ns / 1ps
package cstd_pkg;

    localparam int VAL_W     = 64;
    localparam int LIM_W     = 60;
    localparam int DIV_STEPS = 64;
    localparam int TERMS     = 6;

    localparam logic [2:0] KIND_INT   = 3'd0;
    localparam logic [2:0] KIND_DEC   = 3'd1;
    localparam logic [2:0] KIND_DATE  = 3'd2;
    localparam logic [2:0] KIND_DTIME = 3'd3;

    localparam logic REG_DECIMALS  = 1'b0;
    localparam logic REG_PRECISION = 1'b1;

    localparam logic [4:0] SCALE_MAX = 5'd18;

    typedef enum logic [2:0] {
        PATH_UNSUP,
        PATH_NULL,
        PATH_INT,
        PATH_UP,
        PATH_DOWN,
        PATH_DATE
    } path_t;

    typedef struct packed {
        path_t              path;
        logic               neg;
        logic [4:0]         scale;
        logic [VAL_W-1:0]   val;
        logic [LIM_W-1:0]   rem;
        logic [VAL_W-1:0]   nq;
        logic [LIM_W-1:0]   div;
    } div_t;

    function automatic logic [LIM_W-1:0] pow10(input logic [4:0] n);
        logic [LIM_W-1:0] p;
        case (n)
            5'd0:  p = 60'd1;
            5'd1:  p = 60'd10;
            5'd2:  p = 60'd100;
            5'd3:  p = 60'd1000;
            5'd4:  p = 60'd10000;
            5'd5:  p = 60'd100000;
            5'd6:  p = 60'd1000000;
            5'd7:  p = 60'd10000000;
            5'd8:  p = 60'd100000000;
            5'd9:  p = 60'd1000000000;
            5'd10: p = 60'd10000000000;
            5'd11: p = 60'd100000000000;
            5'd12: p = 60'd1000000000000;
            5'd13: p = 60'd10000000000000;
            5'd14: p = 60'd100000000000000;
            5'd15: p = 60'd1000000000000000;
            5'd16: p = 60'd10000000000000000;
            5'd17: p = 60'd100000000000000000;
            5'd18: p = 60'd1000000000000000000;
            default: p = 60'd1;
        endcase
        return p;
    endfunction

endpackage

### sv/cast_to_scaled_decimal.sv
// Cast of integer, decimal, date and datetime values to a scaled decimal.
//
//  Channel  Ports                                   Direction
//  input    s_valid/s_ready, s_source_*             in
//  result   m_valid/m_ready, m_result_*, m_unsup..  out
//  config   APB psel/penable/pwrite/paddr/pwdata    in, prdata out
//
// One item per cycle while the result is not stalled; decimals are rescaled down by
// the 64-step restoring divider (one quotient bit per stage).
// Reset clears valid bits and sets decimals 0, precision 18.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
module cast_to_scaled_decimal
    import cstd_pkg::*;
#(
    parameter int MAX_DIGITS = 18
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_source_kind,
    input  logic signed [63:0] s_source_value,
    input  logic [4:0]         s_source_scale,
    input  logic               s_source_null,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_result_value,
    output logic [4:0]         m_result_scale,
    output logic               m_result_null,
    output logic               m_unsupported_type
);

    localparam logic [4:0] MAXD = 5'(MAX_DIGITS);

    // configuration
    logic [4:0] tdec_reg;
    logic [6:0] tprec_reg;
    logic [4:0] dec_c_reg, dec_c_next;
    logic [LIM_W-1:0] lim_c_reg, lim_c_next, thr_c_reg, thr_c_next;
    logic [VAL_W-1:0] nlim_c_reg, nlim_c_next;
    logic [4:0] prec_eff;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tdec_reg  <= 5'd0;
            tprec_reg <= 7'd18;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_DECIMALS:  tdec_reg  <= pwdata[4:0];
                REG_PRECISION: tprec_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DECIMALS:  prdata = {27'd0, tdec_reg};
            REG_PRECISION: prdata = {25'd0, tprec_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        dec_c_next = (tdec_reg > MAXD) ? MAXD : tdec_reg;
        prec_eff   = (tprec_reg == 7'd0 || tprec_reg > 7'(MAX_DIGITS))
                     ? MAXD : tprec_reg[4:0];
        lim_c_next  = pow10(prec_eff) - 60'd1;
        nlim_c_next = 64'd0 - {4'd0, lim_c_next};
        // integer threshold: floor(limit / 10^dec)
        thr_c_next  = (prec_eff >= dec_c_next)
                      ? pow10(prec_eff - dec_c_next) - 60'd1 : 60'd0;
    end

    always_ff @(posedge aclk) begin
        dec_c_reg  <= dec_c_next;
        lim_c_reg  <= lim_c_next;
        nlim_c_reg <= nlim_c_next;
        thr_c_reg  <= thr_c_next;
    end

    // pipeline control
    logic adv;
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, r_valid_reg;
    logic dv_valid_reg [DIV_STEPS+1];

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            m_valid     <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++) dv_valid_reg[i] <= 1'b0;
        end else if (adv) begin
            a_valid_reg     <= s_valid;
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            d_valid_reg     <= c_valid_reg;
            dv_valid_reg[0] <= d_valid_reg;
            for (int i = 0; i < DIV_STEPS; i++) dv_valid_reg[i+1] <= dv_valid_reg[i];
            r_valid_reg     <= dv_valid_reg[DIV_STEPS];
            m_valid         <= r_valid_reg;
        end
    end

    // stage A: capture
    logic [2:0]       a_kind_reg;
    logic [VAL_W-1:0] a_raw_reg;
    logic [4:0]       a_scale_reg;
    logic             a_null_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_kind_reg  <= s_source_kind;
            a_raw_reg   <= s_source_value;
            a_scale_reg <= s_source_scale;
            a_null_reg  <= s_source_null;
        end
    end

    // stage B: decode, magnitude, divisor, date terms
    path_t            b_path_reg, b_path_next;
    logic             b_neg_reg, b_neg_next;
    logic [VAL_W-1:0] b_mag_reg, b_mag_next, b_raw_reg;
    logic [LIM_W-1:0] b_div_reg, b_div_next;
    logic [VAL_W-1:0] b_term_reg [TERMS];
    logic [VAL_W-1:0] b_term_next [TERMS];
    logic [4:0]       ss, diff;

    always_comb begin
        b_neg_next = a_raw_reg[63];
        b_mag_next = b_neg_next ? 64'd0 - a_raw_reg : a_raw_reg;
        ss   = (a_scale_reg > SCALE_MAX) ? SCALE_MAX : a_scale_reg;
        diff = (dec_c_reg > ss) ? dec_c_reg - ss : ss - dec_c_reg;
        b_div_next = pow10(diff);
        if (a_kind_reg > KIND_DTIME) begin
            b_path_next = PATH_UNSUP;
        end else if (a_null_reg) begin
            b_path_next = PATH_NULL;
        end else begin
            case (a_kind_reg)
                KIND_INT: b_path_next = PATH_INT;
                KIND_DEC: b_path_next = (dec_c_reg > ss) ? PATH_UP : PATH_DOWN;
                default:  b_path_next = PATH_DATE;
            endcase
        end
        for (int i = 0; i < TERMS; i++) b_term_next[i] = 64'd0;
        if (a_kind_reg == KIND_DATE) begin
            b_term_next[0] = 64'(a_raw_reg[31:16]) * 64'd10000;
            b_term_next[1] = 64'(a_raw_reg[15:12]) * 64'd100;
            b_term_next[2] = 64'(a_raw_reg[11:6]);
        end else begin
            b_term_next[0] = 64'(a_raw_reg[63:48]) * 64'd10000000000;
            b_term_next[1] = 64'(a_raw_reg[47:44]) * 64'd100000000;
            b_term_next[2] = 64'(a_raw_reg[43:38]) * 64'd1000000;
            b_term_next[3] = 64'(a_raw_reg[37:32]) * 64'd10000;
            b_term_next[4] = 64'(a_raw_reg[31:26]) * 64'd100;
            b_term_next[5] = 64'(a_raw_reg[25:20]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_path_reg <= b_path_next;
            b_neg_reg  <= b_neg_next;
            b_mag_reg  <= b_mag_next;
            b_raw_reg  <= a_raw_reg;
            b_div_reg  <= b_div_next;
            for (int i = 0; i < TERMS; i++) b_term_reg[i] <= b_term_next[i];
        end
    end

    // stage C: integer check, date sum, partial products
    path_t            c_path_reg;
    logic             c_neg_reg, c_big_reg;
    logic [VAL_W-1:0] c_mag_reg, c_val_reg, c_val_next;
    logic [4:0]       c_scale_reg, c_scale_next;
    logic [LIM_W-1:0] c_div_reg;
    logic [LIM_W-1:0] c_pp_reg [4];
    logic             int_sat;

    always_comb begin
        int_sat = b_mag_reg > {4'd0, thr_c_reg};
        c_val_next   = 64'd0;
        c_scale_next = 5'd0;
        case (b_path_reg)
            PATH_INT: begin
                c_val_next   = int_sat ? (b_neg_reg ? nlim_c_reg : {4'd0, lim_c_reg})
                                       : b_raw_reg;
                c_scale_next = int_sat ? dec_c_reg : 5'd0;
            end
            PATH_DATE: begin
                c_val_next = b_term_reg[0] + b_term_reg[1] + b_term_reg[2]
                           + b_term_reg[3] + b_term_reg[4] + b_term_reg[5];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_path_reg  <= b_path_reg;
            c_neg_reg   <= b_neg_reg;
            c_mag_reg   <= b_mag_reg;
            c_div_reg   <= b_div_reg;
            c_val_reg   <= c_val_next;
            c_scale_reg <= c_scale_next;
            c_big_reg   <= |b_mag_reg[63:60];
            c_pp_reg[0] <= 60'(b_mag_reg[29:0])  * 60'(b_div_reg[29:0]);
            c_pp_reg[1] <= 60'(b_mag_reg[59:30]) * 60'(b_div_reg[29:0]);
            c_pp_reg[2] <= 60'(b_mag_reg[29:0])  * 60'(b_div_reg[59:30]);
            c_pp_reg[3] <= 60'(b_mag_reg[59:30]) * 60'(b_div_reg[59:30]);
        end
    end

    // stage D: combine the cross products
    path_t            d_path_reg;
    logic             d_neg_reg, d_hi_reg;
    logic [VAL_W-1:0] d_mag_reg, d_val_reg;
    logic [4:0]       d_scale_reg;
    logic [LIM_W-1:0] d_div_reg, d_lo_reg;
    logic [LIM_W:0]   d_mid_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_path_reg  <= c_path_reg;
            d_neg_reg   <= c_neg_reg;
            d_mag_reg   <= c_mag_reg;
            d_div_reg   <= c_div_reg;
            d_val_reg   <= c_val_reg;
            d_scale_reg <= c_scale_reg;
            d_lo_reg    <= c_pp_reg[0];
            d_mid_reg   <= {1'b0, c_pp_reg[1]} + {1'b0, c_pp_reg[2]};
            d_hi_reg    <= c_big_reg || (c_pp_reg[3] != 60'd0);
        end
    end

    // stage E: finish the scale-up product, load the divider and run its steps
    div_t       dv_reg  [DIV_STEPS+1];
    div_t       dv_next [DIV_STEPS+1];
    logic [91:0] full;
    logic        up_sat;
    logic [60:0] rem_sh;
    logic        ge;

    always_comb begin
        full   = 92'(d_lo_reg) + (92'(d_mid_reg) << 30);
        up_sat = d_hi_reg || (full > 92'(lim_c_reg));
        dv_next[0].path  = d_path_reg;
        dv_next[0].neg   = d_neg_reg;
        dv_next[0].scale = d_scale_reg;
        dv_next[0].val   = d_val_reg;
        dv_next[0].rem   = 60'd0;
        dv_next[0].nq    = d_mag_reg;
        dv_next[0].div   = d_div_reg;
        if (d_path_reg == PATH_UP || d_path_reg == PATH_DOWN) begin
            dv_next[0].scale = dec_c_reg;
        end
        // scale-up result travels as a clamped magnitude; sign goes on at the end
        if (d_path_reg == PATH_UP) begin
            dv_next[0].val = up_sat ? {4'd0, lim_c_reg} : {4'd0, full[59:0]};
        end
        for (int i = 0; i < DIV_STEPS; i++) begin
            rem_sh = {dv_reg[i].rem, dv_reg[i].nq[63]};
            ge     = rem_sh >= {1'b0, dv_reg[i].div};
            dv_next[i+1]     = dv_reg[i];
            dv_next[i+1].rem = ge ? 60'(rem_sh - {1'b0, dv_reg[i].div}) : rem_sh[59:0];
            dv_next[i+1].nq  = {dv_reg[i].nq[62:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i <= DIV_STEPS; i++) dv_reg[i] <= dv_next[i];
        end
    end

    // stage R: round half away from zero
    path_t            r_path_reg;
    logic             r_neg_reg;
    logic [4:0]       r_scale_reg;
    logic [VAL_W-1:0] r_val_reg, r_m_reg;
    logic             rnd;

    assign rnd = {dv_reg[DIV_STEPS].rem, 1'b0} >= {1'b0, dv_reg[DIV_STEPS].div};

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_path_reg  <= dv_reg[DIV_STEPS].path;
            r_neg_reg   <= dv_reg[DIV_STEPS].neg;
            r_scale_reg <= dv_reg[DIV_STEPS].scale;
            r_val_reg   <= dv_reg[DIV_STEPS].val;
            r_m_reg     <= dv_reg[DIV_STEPS].nq + 64'(rnd);
        end
    end

    // output stage: clamp and sign
    logic [VAL_W-1:0] mm, mc, o_val;

    always_comb begin
        mm = (r_path_reg == PATH_DOWN) ? r_m_reg : r_val_reg;
        mc = (mm > {4'd0, lim_c_reg}) ? {4'd0, lim_c_reg} : mm;
        o_val = r_val_reg;
        if (r_path_reg == PATH_UP || r_path_reg == PATH_DOWN) begin
            o_val = r_neg_reg ? 64'd0 - mc : mc;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_result_value     <= o_val;
            m_result_scale     <= r_scale_reg;
            m_result_null      <= (r_path_reg == PATH_NULL);
            m_unsupported_type <= (r_path_reg == PATH_UNSUP);
        end
    end

    `include "cast_to_scaled_decimal_assert.svh"

    `CSD_ASSERT_NOW(a_unsup_zero, m_valid && m_unsupported_type, m_result_value == 64'd0 && !m_result_null, "unsupported item carries a value")
    `CSD_ASSERT_NOW(a_null_zero, m_valid && m_result_null, m_result_value == 64'd0 && m_result_scale == 5'd0, "null item carries a value")
    `CSD_ASSERT_NOW(a_scale_max, m_valid, m_result_scale <= SCALE_MAX, "result scale out of range")
    `CSD_ASSERT_NEXT(a_div_valid, dv_valid_reg[0] && adv, dv_valid_reg[1], "item lost in divider")

endmodule
